[hw/rtl/arm_data_processing_execute_top_assert.svh]
// Assertion macros for the data-processing execute block.
`ifndef ARM_DATA_PROCESSING_EXECUTE_TOP_ASSERT_SVH
`define ARM_DATA_PROCESSING_EXECUTE_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define ADE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ADE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ADE_ASSERT_IMPL(label, ante, cons)

`define ADE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hw/rtl/ade_pkg.sv]
package ade_pkg;

   localparam int REG_COUNT = 16;

   typedef logic [$clog2(REG_COUNT)-1:0] ade_ridx_type;

   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;

   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   localparam logic ACTION_MUL = 1'b1;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic         action;
      logic [3:0]   opcode;
      logic         imm_flag;
      logic         set_flags;
      ade_ridx_type first_index;
      ade_ridx_type dest_index;
      logic [11:0]  operand_two;
      logic         accumulate;
      ade_ridx_type mul_left_index;
      ade_ridx_type mul_right_index;
   } ade_req_type;

   typedef struct packed {
      logic [31:0]  result_value;
      ade_ridx_type written_index;
      logic         wrote_register;
      logic         flag_neg;
      logic         flag_zero;
      logic         flag_carry;
   } ade_rsp_type;

   // Decoded request as it waits between the front and the back.
   typedef struct packed {
      ade_req_type        req;
      logic               is_mul;
      logic               op_defined;
      logic               write_rd;
      logic               nz_update;
      logic               c_update;
      ade_ridx_type [2:0] read_index;
   } ade_item_type;

endpackage

[hw/rtl/arm_data_processing_execute_top.sv]
// Execute unit for data-processing and multiply instructions.
// A request carries one decoded instruction on req_valid/req_ready/req_payload.
// Each request produces exactly one response on rsp_valid/rsp_ready/rsp_payload,
// holding the 32-bit result, the destination written and the N, Z, C flags.
// The front decodes requests into a two-entry queue; the back reads the
// register file, shifts, computes and updates the register file and flags.
// A request passes in order through a queue entry, the registered register
// file read with the execute stage, and the response register.
// Throughput is one request per cycle while rsp_ready stays high, set by the
// single execute stage and the registered register file read in front of it.
// Back-to-back dependent instructions are forwarded, so no bubbles appear.
// Reset clears the register file, the flags, the queue and the pipeline.
// When rsp_ready is low the response holds, the execute stage fills, then the
// queue fills, and req_ready drops once the queue is full.
`include "arm_data_processing_execute_top_assert.svh"

module arm_data_processing_execute_top
   import ade_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  ade_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output ade_rsp_type rsp_payload
);

   logic         q_valid;
   logic         q_take;
   ade_item_type q_item;

   ade_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .item_valid  (q_valid),
      .item        (q_item),
      .item_take   (q_take)
   );

   ade_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (q_valid),
      .item        (q_item),
      .item_take   (q_take),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `ADE_ASSERT_IMPL(a_take_needs_item, q_take, q_valid)
   `ADE_ASSERT_IMPL(a_index_only_on_write, rsp_valid && !rsp_payload.wrote_register, rsp_payload.written_index == '0)
   `ADE_ASSERT_NEXT(a_full_queue_holds, !req_ready && !q_take, !req_ready)

endmodule

[hw/rtl/ade_front.sv]
module ade_front
   import ade_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ade_req_type  req_payload,
   output logic         item_valid,
   output ade_item_type item,
   input  logic         item_take
);

   ade_item_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]            count_ff, count_in;
   ade_item_type               decoded;
   logic                       push;
   logic                       op_defined;
   logic                       op_test;

   always_comb begin
      op_defined = 1'b1;
      op_test    = 1'b0;
      unique case (req_payload.opcode)
         OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD, OP_ORR, OP_MOV: op_test = 1'b0;
         OP_TST, OP_TEQ, OP_CMP: op_test = 1'b1;
         default: op_defined = 1'b0;
      endcase
   end

   always_comb begin
      decoded            = '0;
      decoded.req        = req_payload;
      decoded.is_mul     = (req_payload.action == ACTION_MUL);
      decoded.op_defined = op_defined;
      if (decoded.is_mul) begin
         decoded.write_rd      = 1'b1;
         decoded.nz_update     = req_payload.set_flags;
         decoded.c_update      = 1'b0;
         decoded.read_index[0] = req_payload.first_index;
         decoded.read_index[1] = req_payload.mul_left_index;
         decoded.read_index[2] = req_payload.mul_right_index;
      end else begin
         decoded.write_rd      = op_defined && !op_test;
         decoded.nz_update     = op_defined && req_payload.set_flags;
         decoded.c_update      = op_defined && req_payload.set_flags;
         decoded.read_index[0] = req_payload.first_index;
         decoded.read_index[1] = req_payload.operand_two[3:0];
         decoded.read_index[2] = req_payload.operand_two[11:8];
      end
   end

   assign req_ready  = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = item_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !item_take) begin
         count_in = count_ff + 1'b1;
      end else if (!push && item_take) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

[hw/rtl/ade_regfile.sv]
module ade_regfile
   import ade_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  ade_ridx_type           wr_idx,
   input  logic [31:0]            wr_data,
   input  logic                   rd_en,
   input  ade_ridx_type [2:0]     rd_idx,
   output logic [2:0][31:0]       rd_data
);

   // Two copies give three read ports; unwritten entries read as zero.
   logic [31:0]          mem_a [REG_COUNT];
   logic [31:0]          mem_b [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [2:0][31:0]     rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_idx] <= wr_data;
         mem_b[wr_idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff[0] <= valid_ff[rd_idx[0]] ? mem_a[rd_idx[0]] : '0;
         rd_data_ff[1] <= valid_ff[rd_idx[1]] ? mem_a[rd_idx[1]] : '0;
         rd_data_ff[2] <= valid_ff[rd_idx[2]] ? mem_b[rd_idx[2]] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/ade_back.sv]
module ade_back
   import ade_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  ade_item_type item,
   output logic         item_take,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ade_rsp_type  rsp_payload
);

   function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] t;
      t = {v, v} >> n;
      return t[31:0];
   endfunction

   logic             exec_valid_ff, exec_valid_in;
   ade_item_type     exec_item_ff;
   logic [2:0]       fwd_sel_ff, fwd_sel_in;
   logic [31:0]      fwd_data_ff;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;
   logic             carry_ff, carry_in;
   logic             rsp_valid_ff, rsp_valid_in;
   ade_rsp_type      rsp_payload_ff;
   logic             exec_fire;
   logic [2:0][31:0] rd_data;
   logic [31:0]      op_rn, op_rm, op_rs;
   logic [11:0]      op2;
   logic [7:0]       shift_amt;
   logic [5:0]       asr_amt;
   logic [32:0]      lsl_t, lsr_t, asr_t;
   logic [31:0]      ror_v, imm_v;
   logic [31:0]      op_b;
   logic             shift_c;
   logic [32:0]      sum;
   logic [31:0]      prod;
   logic [31:0]      result;
   logic             alu_c;

   assign exec_fire = exec_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign item_take = item_valid && (!exec_valid_ff || exec_fire);

   ade_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (exec_fire && exec_item_ff.write_rd),
      .wr_idx  (exec_item_ff.req.dest_index),
      .wr_data (result),
      .rd_en   (item_take),
      .rd_idx  (item.read_index),
      .rd_data (rd_data)
   );

   assign op_rn = fwd_sel_ff[0] ? fwd_data_ff : rd_data[0];
   assign op_rm = fwd_sel_ff[1] ? fwd_data_ff : rd_data[1];
   assign op_rs = fwd_sel_ff[2] ? fwd_data_ff : rd_data[2];
   assign op2   = exec_item_ff.req.operand_two;

   always_comb begin
      shift_amt = op2[4] ? op_rs[7:0] : {3'b000, op2[11:7]};
      asr_amt   = (shift_amt >= 8'd32) ? 6'd32 : shift_amt[5:0];
      lsl_t     = {1'b0, op_rm} << shift_amt;
      lsr_t     = {op_rm, 1'b0} >> shift_amt;
      asr_t     = 33'($signed({op_rm, 1'b0}) >>> asr_amt);
      ror_v     = ror32(op_rm, shift_amt[4:0]);
      imm_v     = ror32({24'd0, op2[7:0]}, {op2[11:8], 1'b0});
      if (exec_item_ff.req.imm_flag) begin
         op_b    = imm_v;
         shift_c = (op2[11:8] == 4'd0) ? carry_ff : imm_v[31];
      end else if (shift_amt == 8'd0) begin
         op_b    = op_rm;
         shift_c = carry_ff;
      end else begin
         unique case (op2[6:5])
            SH_LSL: {shift_c, op_b} = lsl_t;
            SH_LSR: {op_b, shift_c} = lsr_t;
            SH_ASR: {op_b, shift_c} = asr_t;
            SH_ROR: begin
               op_b    = ror_v;
               shift_c = ror_v[31];
            end
            default: begin
               op_b    = op_rm;
               shift_c = carry_ff;
            end
         endcase
      end
   end

   assign sum  = {1'b0, op_rn} + {1'b0, op_b};
   assign prod = op_rm * op_rs;

   always_comb begin
      result = '0;
      alu_c  = carry_ff;
      if (exec_item_ff.is_mul) begin
         result = prod + (exec_item_ff.req.accumulate ? op_rn : 32'd0);
      end else begin
         unique case (exec_item_ff.req.opcode)
            OP_AND, OP_TST: begin
               result = op_rn & op_b;
               alu_c  = shift_c;
            end
            OP_EOR, OP_TEQ: begin
               result = op_rn ^ op_b;
               alu_c  = shift_c;
            end
            OP_SUB, OP_CMP: begin
               result = op_rn - op_b;
               alu_c  = (op_rn >= op_b);
            end
            OP_RSB: begin
               result = op_b - op_rn;
               alu_c  = (op_b >= op_rn);
            end
            OP_ADD: begin
               result = sum[31:0];
               alu_c  = sum[32];
            end
            OP_ORR: begin
               result = op_rn | op_b;
               alu_c  = shift_c;
            end
            OP_MOV: begin
               result = op_b;
               alu_c  = shift_c;
            end
            default: begin
               result = '0;
               alu_c  = carry_ff;
            end
         endcase
      end
   end

   always_comb begin
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      carry_in = carry_ff;
      if (exec_fire && exec_item_ff.nz_update) begin
         neg_in  = result[31];
         zero_in = (result == 32'd0);
      end
      if (exec_fire && exec_item_ff.c_update) begin
         carry_in = alu_c;
      end
   end

   always_comb begin
      exec_valid_in = exec_valid_ff;
      if (item_take) begin
         exec_valid_in = 1'b1;
      end else if (exec_fire) begin
         exec_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      for (int k = 0; k < 3; k++) begin
         fwd_sel_in[k] = exec_fire && exec_item_ff.write_rd
                         && (exec_item_ff.req.dest_index == item.read_index[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         neg_ff        <= 1'b0;
         zero_ff       <= 1'b0;
         carry_ff      <= 1'b0;
      end else begin
         exec_valid_ff <= exec_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         neg_ff        <= neg_in;
         zero_ff       <= zero_in;
         carry_ff      <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         exec_item_ff <= item;
         fwd_sel_ff   <= fwd_sel_in;
         fwd_data_ff  <= result;
      end
      if (exec_fire) begin
         rsp_payload_ff.result_value   <= result;
         rsp_payload_ff.written_index  <= exec_item_ff.write_rd ?
                                          exec_item_ff.req.dest_index : '0;
         rsp_payload_ff.wrote_register <= exec_item_ff.write_rd;
         rsp_payload_ff.flag_neg       <= neg_in;
         rsp_payload_ff.flag_zero      <= zero_in;
         rsp_payload_ff.flag_carry     <= carry_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[tb/testbench.sv]
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import ade_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;
   localparam int MAX_GAP = 30;
   localparam int HOLD_CYCLES = 150;
   localparam int PHASE_ITEMS = 150;
   localparam int PRESSURE_ITEMS = 20;
   localparam int DRAIN_CYCLES = 10;

   localparam logic ACTION_DP = ~ACTION_MUL;
   localparam logic [3:0] DEFINED_OPS [10] = '{OP_AND, OP_EOR, OP_SUB, OP_RSB, OP_ADD,
                                               OP_TST, OP_TEQ, OP_CMP, OP_ORR, OP_MOV};
   localparam logic [3:0] UNDEFINED_OPS [6] = '{4'd5, 4'd6, 4'd7, 4'd11, 4'd14, 4'd15};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ade_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ade_rsp_type rsp_payload;

   logic [31:0] arch_regs [REG_COUNT] = '{default: '0};
   logic        arch_n = 1'b0;
   logic        arch_z = 1'b0;
   logic        arch_c = 1'b0;

   ade_rsp_type expected_results [$];

   int   send_idle_pct = 0;
   int   recv_stall_pct = 0;
   int   hold_requests = 0;
   int   hold_served = 0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   failure_count = 0;
   int   accepted_count = 0;
   int   mul_count = 0;
   int   undefined_count = 0;
   int   response_count = 0;

   arm_data_processing_execute_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] barrel_shift(input logic [31:0] value,
                                                input logic [1:0] kind, input int amount,
                                                input logic carry_in,
                                                output logic carry_out);
      int r;
      r = amount % 32;
      carry_out = carry_in;
      if (amount == 0) return value;
      case (kind)
         SH_LSL: begin
            if (amount < 32) begin
               carry_out = value[32 - amount];
               return value << amount;
            end
            carry_out = (amount == 32) ? value[0] : 1'b0;
            return '0;
         end
         SH_LSR: begin
            if (amount < 32) begin
               carry_out = value[amount - 1];
               return value >> amount;
            end
            carry_out = (amount == 32) ? value[31] : 1'b0;
            return '0;
         end
         SH_ASR: begin
            if (amount < 32) begin
               carry_out = value[amount - 1];
               return 32'($signed(value) >>> amount);
            end
            carry_out = value[31];
            return {32{value[31]}};
         end
         SH_ROR: begin
            if (r == 0) begin
               carry_out = value[31];
               return value;
            end
            carry_out = value[r - 1];
            return (value >> r) | (value << (32 - r));
         end
      endcase
      return value;
   endfunction

   function automatic ade_rsp_type execute_instruction(input ade_req_type instr);
      ade_rsp_type rsp;
      logic [31:0] rn_val;
      logic [31:0] op_b;
      logic [31:0] res;
      logic        shift_c;
      logic        new_c;
      logic        defined;
      logic        write_rd;
      int          amount;
      rsp = '0;
      res = '0;
      op_b = '0;
      shift_c = arch_c;
      new_c = arch_c;
      defined = 1'b0;
      write_rd = 1'b0;
      rn_val = arch_regs[instr.first_index];
      if (instr.action == ACTION_MUL) begin
         res = arch_regs[instr.mul_left_index] * arch_regs[instr.mul_right_index];
         if (instr.accumulate) res = res + rn_val;
         write_rd = 1'b1;
         if (instr.set_flags) begin
            arch_n = res[31];
            arch_z = (res == '0);
         end
      end else begin
         if (instr.imm_flag) begin
            op_b = barrel_shift({24'd0, instr.operand_two[7:0]}, SH_ROR,
                                2 * instr.operand_two[11:8], arch_c, shift_c);
         end else begin
            if (instr.operand_two[4]) amount = int'(arch_regs[instr.operand_two[11:8]][7:0]);
            else amount = int'(instr.operand_two[11:7]);
            op_b = barrel_shift(arch_regs[instr.operand_two[3:0]], instr.operand_two[6:5],
                                amount, arch_c, shift_c);
         end
         defined = 1'b1;
         case (instr.opcode)
            OP_AND, OP_TST: begin
               res = rn_val & op_b;
               new_c = shift_c;
            end
            OP_EOR, OP_TEQ: begin
               res = rn_val ^ op_b;
               new_c = shift_c;
            end
            OP_SUB, OP_CMP: begin
               res = rn_val - op_b;
               new_c = (rn_val >= op_b);
            end
            OP_RSB: begin
               res = op_b - rn_val;
               new_c = (op_b >= rn_val);
            end
            OP_ADD: begin
               {new_c, res} = {1'b0, rn_val} + {1'b0, op_b};
            end
            OP_ORR: begin
               res = rn_val | op_b;
               new_c = shift_c;
            end
            OP_MOV: begin
               res = op_b;
               new_c = shift_c;
            end
            default: begin
               defined = 1'b0;
               res = '0;
               undefined_count++;
            end
         endcase
         write_rd = defined && !(instr.opcode inside {OP_TST, OP_TEQ, OP_CMP});
         if (defined && instr.set_flags) begin
            arch_n = res[31];
            arch_z = (res == '0);
            arch_c = new_c;
         end
      end
      if (write_rd) arch_regs[instr.dest_index] = res;
      rsp.result_value = res;
      rsp.written_index = write_rd ? instr.dest_index : '0;
      rsp.wrote_register = write_rd;
      rsp.flag_neg = arch_n;
      rsp.flag_zero = arch_z;
      rsp.flag_carry = arch_c;
      return rsp;
   endfunction

   function automatic logic [11:0] imm_operand(input logic [3:0] rot, input logic [7:0] imm);
      return {rot, imm};
   endfunction

   function automatic logic [11:0] const_shift_operand(input logic [4:0] amount,
                                                       input logic [1:0] kind,
                                                       input ade_ridx_type rm);
      return {amount, kind, 1'b0, rm};
   endfunction

   function automatic logic [11:0] reg_shift_operand(input ade_ridx_type rs,
                                                     input logic [1:0] kind,
                                                     input ade_ridx_type rm);
      return {rs, 1'b0, kind, 1'b1, rm};
   endfunction

   function automatic ade_req_type dp_instr(input logic [3:0] opcode, input logic set_flags,
                                            input ade_ridx_type rd, input ade_ridx_type rn,
                                            input logic imm_flag, input logic [11:0] operand);
      ade_req_type instr;
      instr = '0;
      instr.action = ACTION_DP;
      instr.opcode = opcode;
      instr.set_flags = set_flags;
      instr.dest_index = rd;
      instr.first_index = rn;
      instr.imm_flag = imm_flag;
      instr.operand_two = operand;
      return instr;
   endfunction

   function automatic ade_req_type mul_instr(input logic set_flags, input logic accumulate,
                                             input ade_ridx_type rd, input ade_ridx_type rm,
                                             input ade_ridx_type rs, input ade_ridx_type rn);
      ade_req_type instr;
      instr = '0;
      instr.action = ACTION_MUL;
      instr.set_flags = set_flags;
      instr.accumulate = accumulate;
      instr.dest_index = rd;
      instr.mul_left_index = rm;
      instr.mul_right_index = rs;
      instr.first_index = rn;
      return instr;
   endfunction

   function automatic ade_req_type random_instruction();
      ade_req_type instr;
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      instr = bits[$bits(ade_req_type)-1:0];
      instr.action = ($urandom_range(3) == 0) ? ACTION_MUL : ACTION_DP;
      if ($urandom_range(9) < 9) instr.opcode = DEFINED_OPS[$urandom_range(9)];
      else instr.opcode = UNDEFINED_OPS[$urandom_range(5)];
      // Now and then load a small value so that register shifts see amounts below 64.
      if ($urandom_range(7) == 0) begin
         instr.action = ACTION_DP;
         instr.opcode = OP_MOV;
         instr.imm_flag = 1'b1;
         instr.operand_two[11:6] = '0;
      end
      return instr;
   endfunction

   task automatic issue_instruction(input ade_req_type instr);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= instr;
      do @(posedge clock); while (req_ready !== 1'b1);
      expected_results.push_back(execute_instruction(instr));
      accepted_count++;
      if (instr.action == ACTION_MUL) mul_count++;
   endtask

   function automatic void record_failure(input string what);
      failure_count++;
      if (failure_count <= MAX_REPORTS) $display("ERROR: %s", what);
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         record_failure($sformatf("response %0d %s: expected %h, got %h",
                                  response_count, name, want, got));
      end
   endfunction

   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      ade_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         response_count++;
         if (expected_results.size() == 0) begin
            record_failure($sformatf("response %0d arrived with none expected: %h",
                                     response_count, rsp_payload));
         end else begin
            want = expected_results.pop_front();
            compare_field("result_value", want.result_value, rsp_payload.result_value);
            compare_field("written_index", 32'(want.written_index),
                          32'(rsp_payload.written_index));
            compare_field("wrote_register", 32'(want.wrote_register),
                          32'(rsp_payload.wrote_register));
            compare_field("flag_neg", 32'(want.flag_neg), 32'(rsp_payload.flag_neg));
            compare_field("flag_zero", 32'(want.flag_zero), 32'(rsp_payload.flag_zero));
            compare_field("flag_carry", 32'(want.flag_carry), 32'(rsp_payload.flag_carry));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding.",
                  cycle_count, expected_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_directed();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd1, 4'd0, 1'b1, imm_operand(4'd0, 8'hFF)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd2, 4'd0, 1'b1, imm_operand(4'd1, 8'h02)));
      issue_instruction(dp_instr(OP_MOV, 1'b0, 4'd3, 4'd0, 1'b1, imm_operand(4'd4, 8'hFF)));
      issue_instruction(dp_instr(OP_SUB, 1'b1, 4'd5, 4'd0, 1'b1, imm_operand(4'd0, 8'h01)));
      issue_instruction(dp_instr(OP_ADD, 1'b1, 4'd6, 4'd5, 1'b1, imm_operand(4'd0, 8'h01)));
      issue_instruction(dp_instr(OP_RSB, 1'b1, 4'd7, 4'd1, 1'b1, imm_operand(4'd0, 8'hFF)));
      issue_instruction(dp_instr(OP_MOV, 1'b0, 4'd8, 4'd0, 1'b1, imm_operand(4'd0, 8'h20)));
      issue_instruction(dp_instr(OP_MOV, 1'b0, 4'd11, 4'd0, 1'b1,
                                 imm_operand(4'd12, 8'h01)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd12, 4'd0, 1'b0,
                                 reg_shift_operand(4'd8, SH_LSL, 4'd5)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd12, 4'd0, 1'b0,
                                 reg_shift_operand(4'd1, SH_LSR, 4'd5)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd12, 4'd0, 1'b0,
                                 reg_shift_operand(4'd1, SH_ASR, 4'd2)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd12, 4'd0, 1'b0,
                                 reg_shift_operand(4'd8, SH_ROR, 4'd3)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd12, 4'd0, 1'b0,
                                 reg_shift_operand(4'd1, SH_ROR, 4'd3)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd12, 4'd0, 1'b0,
                                 reg_shift_operand(4'd11, SH_LSL, 4'd1)));
      issue_instruction(dp_instr(OP_MOV, 1'b1, 4'd13, 4'd0, 1'b0,
                                 const_shift_operand(5'd0, SH_LSR, 4'd2)));
      issue_instruction(dp_instr(OP_AND, 1'b1, 4'd4, 4'd3, 1'b0,
                                 const_shift_operand(5'd1, SH_ROR, 4'd5)));
      issue_instruction(dp_instr(OP_EOR, 1'b1, 4'd4, 4'd4, 1'b0,
                                 const_shift_operand(5'd31, SH_LSL, 4'd5)));
      issue_instruction(dp_instr(OP_ORR, 1'b1, 4'd4, 4'd4, 1'b0,
                                 const_shift_operand(5'd4, SH_LSR, 4'd1)));
      issue_instruction(dp_instr(OP_TST, 1'b1, 4'd9, 4'd3, 1'b1, imm_operand(4'd0, 8'hFF)));
      issue_instruction(dp_instr(OP_TEQ, 1'b1, 4'd9, 4'd5, 1'b0,
                                 const_shift_operand(5'd0, SH_LSL, 4'd5)));
      issue_instruction(dp_instr(OP_CMP, 1'b1, 4'd9, 4'd1, 1'b0,
                                 const_shift_operand(5'd0, SH_LSL, 4'd5)));
      issue_instruction(mul_instr(1'b1, 1'b0, 4'd14, 4'd5, 4'd5, 4'd0));
      issue_instruction(mul_instr(1'b1, 1'b1, 4'd15, 4'd3, 4'd1, 4'd2));
      issue_instruction(mul_instr(1'b1, 1'b0, 4'd10, 4'd0, 4'd5, 4'd0));
      issue_instruction(dp_instr(UNDEFINED_OPS[0], 1'b1, 4'd10, 4'd5, 1'b1,
                                 imm_operand(4'd0, 8'hFF)));
   endtask

   task automatic test_backpressure();
      int i;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      hold_requests++;
      for (i = 0; i < PRESSURE_ITEMS; i++) issue_instruction(random_instruction());
   endtask

   task automatic test_random_phases();
      int send_levels [4] = '{0, 81, 0, 31};
      int recv_levels [4] = '{0, 0, 81, 31};
      int phase;
      int i;
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_levels[phase];
         recv_stall_pct = recv_levels[phase];
         for (i = 0; i < PHASE_ITEMS; i++) issue_instruction(random_instruction());
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_phases();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Executed %0d requests (%0d multiply, %0d undefined opcode), %0d responses.",
               accepted_count, mul_count, undefined_count, response_count);
      $display("Covered shifter edge cases, a long response stall and four idle/stall mixes.");
      if (failure_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d failures found.", failure_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ade_pkg.sv
hw/rtl/ade_front.sv
hw/rtl/ade_regfile.sv
hw/rtl/ade_back.sv
hw/rtl/arm_data_processing_execute_top.sv
tb/testbench.sv
